// ===== hw/rtl/rgpm_pkg.sv =====
// shared types, template constants and mark selection for the ring glider marker
package rgpm_pkg;

  localparam int ROW_W  = 64;
  localparam int CFG_W  = 7;
  localparam int WIN_N  = 4;
  localparam int MIN_LEN = 4;

  // bit d of each row entry is template offset d, row index selects the nibble
  localparam logic [WIN_N-1:0][3:0] TMPL_BITS = {4'b0001, 4'b1001, 4'b0001, 4'b1111};
  localparam logic [WIN_N-1:0][3:0] TMPL_CARE = {4'b0011, 4'b1111, 4'b1111, 4'b1111};
  // set where a matching start stamps an interior mark, clear for exterior
  localparam logic [WIN_N-1:0][3:0] INT_KIND  = {4'b0010, 4'b0110, 4'b1110, 4'b0000};

  typedef struct packed {
    logic       step;
    logic       fill;
    logic [1:0] fill_row;
  } cell_ctrl_t;

  typedef logic [WIN_N-1:0] col_t;

  // last matching start wins: wrapped starts lie highest, then lower offsets
  function automatic logic [2:0] pick_start(input logic [3:0] hits,
                                            input logic [3:0] wrap,
                                            input logic [3:0] span);
    logic       found;
    logic [1:0] sel;
    found = 1'b0;
    sel   = 2'd0;
    for (int p = 0; p < 2; p++) begin
      for (int d = 0; d < 4; d++) begin
        if (!found && hits[d] && span[d] && (wrap[d] == (p == 0))) begin
          found = 1'b1;
          sel   = 2'(d);
        end
      end
    end
    return {found, sel};
  endfunction

endpackage

// ===== hw/rtl/ring_glider_pattern_marker_top.sv =====
// ring glider marker top: cell row, ring wrap routing, fill control and output register
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------------
//  in       | in_valid/in_stall  | in_row_cells[63:0]
//  out      | out_valid/out_stall| out_exterior_mask, out_interior_mask,
//           |                    | out_plain_alive_mask (64 bits each)
//  cfg      | cfg_we             | cfg_ring_length[6:0]
//
// one row per cycle while in_stall is low: match and stamp for all cells are combinational,
// the shift is registered, and the result sits in an output register in the cycle after the item is taken.
// the first four rows after reset only fill the window and give no result.
// a synchronous reset clears window, marks, fill count, and sets ring length to max.
// in_stall is high only while a result waits and out_stall holds it.
module ring_glider_pattern_marker_top
  import rgpm_pkg::*;
#(
  parameter int MAX_CELLS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ROW_W-1:0] in_row_cells,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ROW_W-1:0] out_exterior_mask,
  output logic [ROW_W-1:0] out_interior_mask,
  output logic [ROW_W-1:0] out_plain_alive_mask,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_ring_length
);

  localparam int LEN_W = $clog2(MAX_CELLS + 1);
  localparam int IDX_W = $clog2(MAX_CELLS);

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [2:0]       fill_cnt_r, fill_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0] ext_r, int_r, plain_r;
  logic             accept, full;
  cell_ctrl_t       ctrl;

  col_t               cols [MAX_CELLS];
  col_t               head_col [4];
  logic [MAX_CELLS-1:0] hit_vec;
  logic [MAX_CELLS-1:0] ring_vec;
  logic [3:1]         hit_tail;
  logic [ROW_W-1:0]   ext_vec, int_vec, plain_vec;

  assign full     = fill_cnt_r[2];
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign ctrl.step     = accept & full;
  assign ctrl.fill     = accept & ~full;
  assign ctrl.fill_row = fill_cnt_r[1:0];

  // config value clamped to the supported ring lengths
  always_comb begin
    len_nxt = len_r;
    if (cfg_we) begin
      if (cfg_ring_length < CFG_W'(MIN_LEN)) begin
        len_nxt = LEN_W'(MIN_LEN);
      end else if (cfg_ring_length > CFG_W'(MAX_CELLS)) begin
        len_nxt = LEN_W'(MAX_CELLS);
      end else begin
        len_nxt = LEN_W'(cfg_ring_length);
      end
    end
  end

  always_comb begin
    fill_cnt_nxt = fill_cnt_r;
    if (ctrl.fill) begin
      fill_cnt_nxt = fill_cnt_r + 3'd1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.step) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= LEN_W'(MAX_CELLS);
      fill_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      ext_r   <= ext_vec;
      int_r   <= int_vec;
      plain_r <= plain_vec;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_exterior_mask    = ext_r;
  assign out_interior_mask    = int_r;
  assign out_plain_alive_mask = plain_r;

  // first columns feed the cells whose template runs past the ring end
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      head_col[j] = cols[j];
    end
  end

  // hits of the last ring cells feed stamping at the ring start
  always_comb begin
    for (int j = 1; j < 4; j++) begin
      hit_tail[j] = hit_vec[IDX_W'(len_r - LEN_W'(j))];
    end
  end

  genvar k, d;
  generate
    for (k = ROW_W; k > MAX_CELLS; k--) begin : g_pad
      assign ext_vec[k-1]   = 1'b0;
      assign int_vec[k-1]   = 1'b0;
      assign plain_vec[k-1] = 1'b0;
    end

    for (k = 0; k < MAX_CELLS; k++) begin : g_cell
      logic [2:0][WIN_N-1:0] nb_col;
      logic [2:0]            nb_hit;
      logic                  in_ring;

      assign in_ring     = LEN_W'(k) < len_r;
      assign ring_vec[k] = in_ring;

      for (d = 1; d < 4; d++) begin : g_nb
        logic [LEN_W-1:0] wi;
        assign wi = LEN_W'(k + d) - len_r;
        if (k + d < MAX_CELLS) begin : g_fwd
          assign nb_col[d-1] = (LEN_W'(k + d) < len_r) ? cols[k+d] : head_col[wi[1:0]];
        end else begin : g_fwd_wrap
          assign nb_col[d-1] = head_col[wi[1:0]];
        end
        if (k >= d) begin : g_back
          assign nb_hit[d-1] = hit_vec[k-d];
        end else begin : g_back_wrap
          assign nb_hit[d-1] = hit_tail[d-k];
        end
      end

      rgpm_cell #(
        .WRAP({(3 > k), (2 > k), (1 > k), 1'b0})
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .row_bit (in_row_cells[k] & in_ring),
        .in_ring (in_ring),
        .nb_col  (nb_col),
        .nb_hit  (nb_hit),
        .col     (cols[k]),
        .hit     (hit_vec[k]),
        .ext0    (ext_vec[k]),
        .int0    (int_vec[k]),
        .plain0  (plain_vec[k])
      );
    end
  endgenerate

  // a step always leaves a result behind it
  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.step |=> out_valid)
    else $error("step did not produce a result");

  // fill count never runs past the window depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cnt_r <= 3'd4)
    else $error("fill count out of range");

  // a cell carries one kind of mark at most
  a_marks_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_exterior_mask & out_interior_mask) == '0))
    else $error("exterior and interior marks overlap");

  // the lowest cells always lie inside the ring
  a_ring_min: assert property (@(posedge clk) disable iff (!rst_n)
    ring_vec[3:0] == 4'b1111)
    else $error("ring shorter than minimum");

endmodule

// ===== hw/rtl/rgpm_cell.sv =====
// one ring column: four window bits with their marks, template match and stamping
module rgpm_cell
  import rgpm_pkg::*;
#(
  parameter logic [3:0] WRAP = 4'b0000
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_ctrl_t           ctrl,
  input  logic                 row_bit,
  input  logic                 in_ring,
  input  logic [2:0][WIN_N-1:0] nb_col,
  input  logic [2:0]           nb_hit,
  output col_t                 col,
  output logic                 hit,
  output logic                 ext0,
  output logic                 int0,
  output logic                 plain0
);

  col_t win_r, win_nxt;
  col_t ext_r, ext_nxt;
  col_t int_r, int_nxt;
  col_t ext_s, int_s;
  logic [3:0] cand;
  logic [WIN_N-1:0][2:0] pick;

  assign col  = win_r;
  assign cand = {nb_hit, hit};

  always_comb begin
    logic [3:0] v;
    logic       ok;
    ok = in_ring;
    for (int r = 0; r < WIN_N; r++) begin
      v  = {nb_col[2][r], nb_col[1][r], nb_col[0][r], win_r[r]};
      ok = ok && (((v ^ TMPL_BITS[r]) & TMPL_CARE[r]) == 4'b0000);
    end
    hit = ok;
  end

  always_comb begin
    for (int r = 0; r < WIN_N; r++) begin
      pick[r] = pick_start(cand, WRAP, TMPL_CARE[r]);
      if (pick[r][2] && in_ring) begin
        int_s[r] = INT_KIND[r][pick[r][1:0]];
        ext_s[r] = ~INT_KIND[r][pick[r][1:0]];
      end else begin
        int_s[r] = int_r[r];
        ext_s[r] = ext_r[r];
      end
    end
  end

  assign ext0   = ext_s[0] & in_ring;
  assign int0   = int_s[0] & in_ring;
  assign plain0 = win_r[0] & ~ext_s[0] & ~int_s[0] & in_ring;

  always_comb begin
    win_nxt = win_r;
    ext_nxt = ext_r;
    int_nxt = int_r;
    if (ctrl.step) begin
      win_nxt = {row_bit, win_r[WIN_N-1:1]};
      ext_nxt = {1'b0, ext_s[WIN_N-1:1]};
      int_nxt = {1'b0, int_s[WIN_N-1:1]};
    end else if (ctrl.fill) begin
      win_nxt[ctrl.fill_row] = row_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      ext_r <= '0;
      int_r <= '0;
    end else begin
      win_r <= win_nxt;
      ext_r <= ext_nxt;
      int_r <= int_nxt;
    end
  end

endmodule

// ===== dv/ring_glider_pattern_marker_top_tb.sv =====
// self-checking testbench for the ring glider pattern marker top level

// template as seen by the predictor: entry r is window row r, bit d is offset d
localparam logic [3:0][3:0] GLIDER_BITS = {4'b0001, 4'b1001, 4'b0001, 4'b1111};
localparam logic [3:0][3:0] GLIDER_CARE = {4'b0011, 4'b1111, 4'b1111, 4'b1111};
// set where a match leaves an interior mark, clear for exterior
localparam logic [3:0][3:0] GLIDER_INT  = {4'b0010, 4'b0110, 4'b1110, 4'b0000};

typedef struct {
  logic [63:0] exterior;
  logic [63:0] interior;
  logic [63:0] plain;
} mark_masks_t;

class glider_scoreboard;
  logic [63:0]  rows [4];
  logic [63:0]  ext_marks [4];
  logic [63:0]  int_marks [4];
  int unsigned  rows_held;
  logic [6:0]   ring_len;
  mark_masks_t  masks_due [$];
  int unsigned  fails;
  int unsigned  checked;
  int unsigned  hit_steps;

  function new();
    for (int r = 0; r < 4; r++) begin
      rows[r] = '0;
      ext_marks[r] = '0;
      int_marks[r] = '0;
    end
    rows_held = 0;
    ring_len  = 7'd64;
    fails     = 0;
    checked   = 0;
    hit_steps = 0;
  endfunction

  function void set_len(logic [6:0] len);
    ring_len = len;
  endfunction

  function int unsigned eff_len();
    int unsigned n;
    n = ring_len;
    if (n < 4) n = 4;
    if (n > 64) n = 64;
    return n;
  endfunction

  function int unsigned pending();
    return masks_due.size();
  endfunction

  // accepted input row: fill the window or run one marking step
  function void note_row(logic [63:0] row_in);
    int unsigned n;
    int unsigned pos;
    logic [63:0] m;
    logic [63:0] row;
    logic        hit;
    logic        any_hit;
    mark_masks_t res;
    n = eff_len();
    m = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    row = row_in & m;
    any_hit = 1'b0;
    if (rows_held < 4) begin
      rows[rows_held] = row;
      rows_held++;
      return;
    end
    for (int i = 0; i < n; i++) begin
      hit = 1'b1;
      for (int r = 0; r < 4; r++)
        for (int d = 0; d < 4; d++)
          if (GLIDER_CARE[r][d] && rows[r][(i + d) % n] != GLIDER_BITS[r][d]) hit = 1'b0;
      if (hit) begin
        any_hit = 1'b1;
        // later starts overwrite marks left by earlier ones
        for (int r = 0; r < 4; r++)
          for (int d = 0; d < 4; d++)
            if (GLIDER_CARE[r][d]) begin
              pos = (i + d) % n;
              ext_marks[r][pos] = !GLIDER_INT[r][d];
              int_marks[r][pos] = GLIDER_INT[r][d];
            end
      end
    end
    if (any_hit) hit_steps++;
    res.exterior = ext_marks[0] & m;
    res.interior = int_marks[0] & m;
    res.plain    = rows[0] & ~ext_marks[0] & ~int_marks[0] & m;
    masks_due.push_back(res);
    for (int r = 0; r < 3; r++) begin
      rows[r] = rows[r + 1];
      ext_marks[r] = ext_marks[r + 1];
      int_marks[r] = int_marks[r + 1];
    end
    rows[3] = row;
    ext_marks[3] = '0;
    int_marks[3] = '0;
  endfunction

  function void check_result(logic [63:0] ext, logic [63:0] intr, logic [63:0] plain);
    mark_masks_t exp_m;
    if (masks_due.size() == 0) begin
      $error("result item with no expectation waiting: ext %h int %h plain %h",
             ext, intr, plain);
      fails++;
      return;
    end
    exp_m = masks_due.pop_front();
    checked++;
    if (ext !== exp_m.exterior) begin
      $error("exterior_mask mismatch: expected %h, got %h", exp_m.exterior, ext);
      fails++;
    end
    if (intr !== exp_m.interior) begin
      $error("interior_mask mismatch: expected %h, got %h", exp_m.interior, intr);
      fails++;
    end
    if (plain !== exp_m.plain) begin
      $error("plain_alive_mask mismatch: expected %h, got %h", exp_m.plain, plain);
      fails++;
    end
  endfunction
endclass

module ring_glider_pattern_marker_top_tb;
  import rgpm_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ROW_W-1:0] in_row_cells = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ROW_W-1:0] out_exterior_mask;
  logic [ROW_W-1:0] out_interior_mask;
  logic [ROW_W-1:0] out_plain_alive_mask;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_ring_length = '0;

  glider_scoreboard sb = new();

  logic [63:0] group_rows [4];
  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned rows_sent = 0;
  int unsigned settings_used = 0;
  int unsigned idle_cycles = 0;

  ring_glider_pattern_marker_top DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_row_cells         (in_row_cells),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_exterior_mask    (out_exterior_mask),
    .out_interior_mask    (out_interior_mask),
    .out_plain_alive_mask (out_plain_alive_mask),
    .cfg_we               (cfg_we),
    .cfg_ring_length      (cfg_ring_length)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] rand_row();
    return {$urandom, $urandom};
  endfunction

  function automatic void clear_group();
    for (int r = 0; r < 4; r++) group_rows[r] = '0;
  endfunction

  function automatic void plant_glider(int unsigned start, int unsigned n);
    int unsigned pos;
    for (int r = 0; r < 4; r++)
      for (int d = 0; d < 4; d++)
        if (GLIDER_CARE[r][d]) begin
          pos = (start + d) % n;
          group_rows[r][pos] = GLIDER_BITS[r][d];
        end
  endfunction

  // four consecutive rows: mostly planted gliders on sparse noise, some broken or pure noise
  function automatic void make_random_group(int unsigned n);
    int unsigned kind;
    int unsigned start;
    int unsigned r;
    int unsigned d;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 4; i++) begin
      case (kind)
        7: group_rows[i] = rand_row();
        8: begin
          case ($urandom_range(0, 2))
            0: group_rows[i] = '0;
            1: group_rows[i] = '1;
            default: group_rows[i] = rand_row() | rand_row();
          endcase
        end
        default: group_rows[i] = rand_row() & rand_row() & rand_row();
      endcase
    end
    if (kind <= 6) begin
      repeat ($urandom_range(1, 3)) plant_glider($urandom_range(0, n - 1), n);
    end else if (kind == 9) begin
      start = $urandom_range(0, n - 1);
      plant_glider(start, n);
      r = $urandom_range(0, 3);
      d = (r == 3) ? $urandom_range(0, 1) : $urandom_range(0, 3);
      group_rows[r][(start + d) % n] = ~group_rows[r][(start + d) % n];
    end
  endfunction

  task automatic send_row(input logic [63:0] row);
    int unsigned gap;
    gap = tx_gaps_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_row_cells <= row;
    do @(posedge clk); while (in_stall);
    sb.note_row(row);
    rows_sent++;
  endtask

  task automatic send_group();
    for (int r = 0; r < 4; r++) send_row(group_rows[r]);
  endtask

  task automatic drain_rows();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // fill-only rows give no result, so allow the pipeline to settle before the write
  task automatic write_ring_length(input logic [CFG_W-1:0] len);
    drain_rows();
    repeat (4) @(posedge clk);
    cfg_we          <= 1'b1;
    cfg_ring_length <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_len(len);
    settings_used++;
  endtask

  // result side
  initial begin
    int unsigned wait_cycles;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      wait_cycles = rx_gaps_on ? $urandom_range(0, 15) : 0;
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_exterior_mask, out_interior_mask, out_plain_alive_mask);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] lengths [10];
    lengths = '{7'd4, 7'd0, 7'd127, 7'd5, 7'd65, 7'd3, 7'd17, 7'd63, 7'd64, 7'd0};
    lengths[9] = CFG_W'($urandom_range(0, 127));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows at the reset ring length
    send_row('1);
    send_row('0);
    send_row(64'hA5A5_5A5A_0F0F_F0F0);
    send_row(64'h8000_0000_0000_0001);
    clear_group();
    plant_glider(0, 64);
    plant_glider(20, 64);
    send_group();
    // glider wrapping across the ring seam
    clear_group();
    plant_glider(62, 64);
    send_group();
    // nearly a glider, one cell off
    clear_group();
    plant_glider(40, 64);
    group_rows[2][43] = 1'b0;
    send_group();
    send_row('1);
    send_row('0);
    send_row('0);
    send_row('0);

    // stored rows stay across each length change
    for (int p = 0; p < 10; p++) begin
      write_ring_length(lengths[p]);
      tx_gaps_on = (p % 3) != 1 && p != 3 && p != 6;
      rx_gaps_on = (p % 3) != 2 && p != 6;
      for (int g = 0; g < 20; g++) begin
        if (p == 3 && g == 5) hold_req = 1'b1;
        if (p == 5 && g == 10) drain_rows();
        make_random_group(sb.eff_len());
        send_group();
      end
    end

    drain_rows();
    repeat (8) @(posedge clk);
    $display("sent %0d rows across %0d ring length settings; %0d results checked",
             rows_sent, settings_used, sb.checked);
    $display("%0d marking steps stamped at least one template match", sb.hit_steps);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
